// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BTCB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btcb: check failed");

// Next-cycle implication, disabled during reset.
`define BTCB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btcb: check failed");

// Next-cycle implication, also checked across reset.
`define BTCB_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("btcb: check failed");

`endif

// ----- hdl/btcb_pkg.sv -----
package btcb_pkg;

   localparam int DEF_MAX_IMAGE_SIDE  = 128;
   localparam int DEF_MAX_SCREEN_SIDE = 1024;

   localparam int ADDR_W = 32;
   localparam int PIX_W  = 16;
   localparam int CSR_DW = 32;
   localparam int CSR_IW = 3;

   typedef enum logic [CSR_IW-1:0] {
      CSR_FB_BASE,
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT,
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_TILE_MODE,
      CSR_CENTER_MODE
   } csr_index_type;

   localparam int RST_SCREEN_WIDTH  = 320;
   localparam int RST_SCREEN_HEIGHT = 240;
   localparam int RST_IMAGE_WIDTH   = 128;
   localparam int RST_IMAGE_HEIGHT  = 128;

   localparam logic [PIX_W-1:0] BLUE_MASK  = 16'h001F;
   localparam logic [PIX_W-1:0] RED_MASK   = 16'hF800;
   localparam logic [PIX_W-1:0] GREEN_MASK = 16'h07E0;
   localparam int               RB_SHIFT   = 11;

   function automatic logic [PIX_W-1:0] swap_red_blue(input logic [PIX_W-1:0] c);
      return ((c & BLUE_MASK) << RB_SHIFT) | ((c & RED_MASK) >> RB_SHIFT) | (c & GREEN_MASK);
   endfunction

endpackage

// ----- hdl/btcb_if.sv -----
interface btcb_req_if
   import btcb_pkg::*;
#(
   parameter int CW  = 10,
   parameter int IXW = 14
);
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [CW-1:0]    screen_x;
   logic [CW-1:0]    screen_y;
   logic [IXW-1:0]   pixel_index;
   logic [PIX_W-1:0] pixel_value;

   modport source (
      output valid, req_type, screen_x, screen_y, pixel_index, pixel_value,
      input  ready
   );
   modport sink (
      input  valid, req_type, screen_x, screen_y, pixel_index, pixel_value,
      output ready
   );
endinterface

interface btcb_rsp_if
   import btcb_pkg::*;
;
   logic              valid;
   logic              ready;
   logic              valid_res;
   logic [ADDR_W-1:0] address;
   logic [PIX_W-1:0]  pixel;

   modport source (
      output valid, valid_res, address, pixel,
      input  ready
   );
   modport sink (
      input  valid, valid_res, address, pixel,
      output ready
   );
endinterface

// ----- hdl/bitmap_tile_center_blit_core.sv -----
// Result path: a map item's result passes the entry stage, the division stages, the fix,
// index and store stages and the output register; load items give no result.
// Throughput: one item per cycle unless the skid stage is full; the tiling remainder is a
// restoring divider, one quotient bit per stage; the image store has one port at a fixed stage.
// Reset (synchronous): registers return to their reset values, pipeline and output empty;
// the image store is not cleared.
module bitmap_tile_center_blit_core
   import btcb_pkg::*;
#(
   parameter int MAX_IMAGE_SIDE  = DEF_MAX_IMAGE_SIDE,
   parameter int MAX_SCREEN_SIDE = DEF_MAX_SCREEN_SIDE
)
(
   input  logic              clock,
   input  logic              reset,
   btcb_req_if.sink          req_in,
   btcb_rsp_if.source        rsp_out,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data
);

   localparam int CW    = $clog2(MAX_SCREEN_SIDE);
   localparam int SWW   = CW + 1;
   localparam int IB    = $clog2(MAX_IMAGE_SIDE);
   localparam int IWW   = IB + 1;
   localparam int IXW   = 2 * IB;
   localparam int DEPTH = 1 << IXW;
   localparam int DW    = CW + IWW;
   localparam int AW    = (SWW > IWW) ? SWW : IWW;
   localparam int PW    = CW + SWW;
   localparam int FIX   = CW + 1;
   localparam int IDX   = CW + 2;
   localparam int NS    = CW + 4;

   localparam int RST_SW = (RST_SCREEN_WIDTH  > MAX_SCREEN_SIDE) ? MAX_SCREEN_SIDE : RST_SCREEN_WIDTH;
   localparam int RST_SH = (RST_SCREEN_HEIGHT > MAX_SCREEN_SIDE) ? MAX_SCREEN_SIDE : RST_SCREEN_HEIGHT;
   localparam int RST_IW = (RST_IMAGE_WIDTH   > MAX_IMAGE_SIDE)  ? MAX_IMAGE_SIDE  : RST_IMAGE_WIDTH;
   localparam int RST_IH = (RST_IMAGE_HEIGHT  > MAX_IMAGE_SIDE)  ? MAX_IMAGE_SIDE  : RST_IMAGE_HEIGHT;

   typedef struct packed {
      logic              is_map;
      logic              ok;
      logic              neg_x;
      logic              neg_y;
      logic [CW-1:0]     rem_x;
      logic [CW-1:0]     rem_y;
      logic [ADDR_W-1:0] addr;
      logic [IXW-1:0]    idx;
      logic [PIX_W-1:0]  value;
   } pipe_type;

   typedef struct packed {
      logic              valid_res;
      logic [ADDR_W-1:0] address;
      logic [PIX_W-1:0]  pixel;
   } res_type;

   // configuration
   logic [ADDR_W-1:0] fb_base_ff;
   logic [SWW-1:0]    screen_width_ff;
   logic [SWW-1:0]    screen_height_ff;
   logic [IWW-1:0]    image_width_ff;
   logic [IWW-1:0]    image_height_ff;
   logic              tile_mode_ff;
   logic              center_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_base_ff       <= '0;
         screen_width_ff  <= SWW'(RST_SW);
         screen_height_ff <= SWW'(RST_SH);
         image_width_ff   <= IWW'(RST_IW);
         image_height_ff  <= IWW'(RST_IH);
         tile_mode_ff     <= 1'b0;
         center_mode_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FB_BASE:       fb_base_ff       <= csr_data[ADDR_W-1:0];
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data[SWW-1:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data[SWW-1:0];
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_data[IWW-1:0];
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_data[IWW-1:0];
            CSR_TILE_MODE:     tile_mode_ff     <= csr_data[0];
            CSR_CENTER_MODE:   center_mode_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [SWW-1:0] sw, sh;
   logic [IWW-1:0] iw, ih;
   logic [CW-1:0]  off_x, off_y;

   always_comb begin
      sw = (screen_width_ff  > SWW'(MAX_SCREEN_SIDE)) ? SWW'(MAX_SCREEN_SIDE) : screen_width_ff;
      sh = (screen_height_ff > SWW'(MAX_SCREEN_SIDE)) ? SWW'(MAX_SCREEN_SIDE) : screen_height_ff;
      iw = (image_width_ff   > IWW'(MAX_IMAGE_SIDE))  ? IWW'(MAX_IMAGE_SIDE)  : image_width_ff;
      ih = (image_height_ff  > IWW'(MAX_IMAGE_SIDE))  ? IWW'(MAX_IMAGE_SIDE)  : image_height_ff;
      off_x = '0;
      off_y = '0;
      if (center_mode_ff && (AW'(iw) < AW'(sw))) begin
         off_x = CW'((AW'(sw) - AW'(iw)) >> 1);
      end
      if (center_mode_ff && (AW'(ih) < AW'(sh))) begin
         off_y = CW'((AW'(sh) - AW'(ih)) >> 1);
      end
   end

   // one restoring-division step: subtract img << b when it fits
   function automatic logic [CW-1:0] div_step(input logic [CW-1:0] rem,
                                              input logic [IWW-1:0] img,
                                              input int b);
      logic [DW-1:0] top;
      top = DW'(rem >> b);
      if (top >= DW'(img)) begin
         return CW'(DW'(rem) - (DW'(img) << b));
      end
      return rem;
   endfunction

   // handshake and pipeline control
   logic          skid_v_ff;
   logic          out_v_ff;
   logic          adv;
   logic          accept;
   logic [NS-1:0] vld_ff;

   assign adv          = !skid_v_ff;
   assign req_in.ready = !skid_v_ff;
   assign accept       = req_in.valid && !skid_v_ff;

   // entry stage
   pipe_type       entry;
   logic [CW:0]    d_x, d_y;
   logic           ok_x, ok_y;

   always_comb begin
      d_x = {1'b0, req_in.screen_x} - {1'b0, off_x};
      d_y = {1'b0, req_in.screen_y} - {1'b0, off_y};
      entry.is_map = req_in.req_type;
      entry.neg_x  = d_x[CW];
      entry.neg_y  = d_y[CW];
      entry.rem_x  = d_x[CW] ? CW'(-d_x) : CW'(d_x);
      entry.rem_y  = d_y[CW] ? CW'(-d_y) : CW'(d_y);
      ok_x = tile_mode_ff || (!entry.neg_x && (DW'(entry.rem_x) < DW'(iw)));
      ok_y = tile_mode_ff || (!entry.neg_y && (DW'(entry.rem_y) < DW'(ih)));
      entry.ok = (SWW'(req_in.screen_x) < sw) && (SWW'(req_in.screen_y) < sh) &&
                 (iw != '0) && (ih != '0) && ok_x && ok_y;
      entry.addr  = ADDR_W'(PW'(req_in.screen_y) * PW'(sw) + PW'(req_in.screen_x));
      entry.idx   = req_in.pixel_index;
      entry.value = req_in.pixel_value;
   end

   pipe_type pipe_ff [NS];
   pipe_type pipe_in [NS];

   assign pipe_in[0] = entry;

   for (genvar k = 1; k < NS; k++) begin : g_stage
      if (k <= CW) begin : g_div
         always_comb begin
            pipe_in[k]       = pipe_ff[k-1];
            pipe_in[k].rem_x = div_step(pipe_ff[k-1].rem_x, iw, CW - k);
            pipe_in[k].rem_y = div_step(pipe_ff[k-1].rem_y, ih, CW - k);
            if (k == 1) begin
               pipe_in[k].addr = fb_base_ff + (pipe_ff[k-1].addr << 1);
            end
         end
      end else if (k == FIX) begin : g_fix
         // negative offset distance: remainder folds back to img - r
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            if (pipe_ff[k-1].neg_x && (pipe_ff[k-1].rem_x != '0)) begin
               pipe_in[k].rem_x = CW'(DW'(iw) - DW'(pipe_ff[k-1].rem_x));
            end
            if (pipe_ff[k-1].neg_y && (pipe_ff[k-1].rem_y != '0)) begin
               pipe_in[k].rem_y = CW'(DW'(ih) - DW'(pipe_ff[k-1].rem_y));
            end
         end
      end else if (k == IDX) begin : g_idx
         always_comb begin
            pipe_in[k] = pipe_ff[k-1];
            if (pipe_ff[k-1].is_map) begin
               pipe_in[k].idx = IXW'(IXW'(pipe_ff[k-1].rem_y) * IXW'(iw) +
                                     IXW'(pipe_ff[k-1].rem_x));
            end
         end
      end else begin : g_mem
         assign pipe_in[k] = pipe_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // image store: loads write and maps read at the same stage, so order is kept
   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_ff;
   logic             mem_we;

   assign mem_we = adv && vld_ff[IDX] && !pipe_ff[IDX].is_map;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pipe_ff[IDX].idx] <= pipe_ff[IDX].value;
      end
      if (adv) begin
         rd_ff <= mem[pipe_ff[IDX].idx];
      end
   end

   // output register with skid stage
   res_type res_in;
   res_type out_ff;
   res_type skid_ff;
   logic    tail_v;
   logic    out_take;

   always_comb begin
      res_in.valid_res = pipe_ff[NS-1].ok;
      res_in.address   = pipe_ff[NS-1].addr;
      res_in.pixel     = pipe_ff[NS-1].ok ? swap_red_blue(rd_ff) : '0;
   end

   assign tail_v   = vld_ff[NS-1] && pipe_ff[NS-1].is_map;
   assign out_take = !out_v_ff || rsp_out.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_v_ff) begin
            out_ff    <= skid_ff;
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_ff   <= res_in;
            out_v_ff <= tail_v;
         end
      end else if (tail_v && adv) begin
         skid_ff   <= res_in;
         skid_v_ff <= 1'b1;
      end
   end

   assign rsp_out.valid     = out_v_ff;
   assign rsp_out.valid_res = out_ff.valid_res;
   assign rsp_out.address   = out_ff.address;
   assign rsp_out.pixel     = out_ff.pixel;

endmodule

// ----- hdl/btcb_checker.sv -----
`include "assert_macros.svh"

module btcb_checker
   import btcb_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              valid_res,
   input logic [ADDR_W-1:0] address,
   input logic [PIX_W-1:0]  pixel
);

   logic [ADDR_W+PIX_W:0] rsp_payload;

   assign rsp_payload = {valid_res, address, pixel};

   `BTCB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `BTCB_ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
   `BTCB_ASSERT_IMP(a_skid_only_when_held, clock, reset, !req_ready, rsp_valid)
   `BTCB_ASSERT_IMP(a_invalid_zero_pixel, clock, reset, rsp_valid && !valid_res, pixel == '0)

endmodule

bind bitmap_tile_center_blit_core btcb_checker u_btcb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_in.ready),
   .rsp_valid (rsp_out.valid),
   .rsp_ready (rsp_out.ready),
   .valid_res (rsp_out.valid_res),
   .address   (rsp_out.address),
   .pixel     (rsp_out.pixel)
);

// ----- verif/tb_bitmap_tile_center_blit_core.sv -----
module tb_bitmap_tile_center_blit_core;
   import btcb_pkg::*;

   localparam int STORE_DEPTH  = DEF_MAX_IMAGE_SIDE * DEF_MAX_IMAGE_SIDE;
   localparam int SETTLE_TICKS = 20;
   localparam int CHUNK_ITEMS  = 50;
   localparam logic [CSR_IW-1:0] CSR_SPARE = 3'd7;

   typedef enum logic {OP_LOAD, OP_MAP} blit_op_type;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      blit_op_type op;
      logic [9:0]  x;
      logic [9:0]  y;
      logic [13:0] index;
      logic [15:0] value;
   } blit_req_type;

   typedef struct packed {
      logic        valid_res;
      logic [31:0] address;
      logic [15:0] pixel;
   } blit_result_type;

   typedef struct packed {
      blit_op_type op;
      logic [9:0]  x;
      logic [9:0]  y;
      logic [13:0] index;
      logic [15:0] value;
      logic        typed;
      logic        exp_valid;
      logic [31:0] exp_address;
      logic [15:0] exp_pixel;
   } directed_row_type;

   typedef struct packed {
      logic [31:0] base;
      logic [10:0] sw;
      logic [10:0] sh;
      logic [7:0]  iw;
      logic [7:0]  ih;
      logic        tile;
      logic        center;
   } blit_setup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_we;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_data;

   btcb_req_if req_bus();
   btcb_rsp_if rsp_bus();

   bitmap_tile_center_blit_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_in   (req_bus),
      .rsp_out  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always #4 clock = ~clock;

   // shadow of the block's registers and image store
   logic [31:0] cfg_fb_base   = 32'd0;
   logic [10:0] cfg_screen_w  = 11'(RST_SCREEN_WIDTH);
   logic [10:0] cfg_screen_h  = 11'(RST_SCREEN_HEIGHT);
   logic [7:0]  cfg_image_w   = 8'(RST_IMAGE_WIDTH);
   logic [7:0]  cfg_image_h   = 8'(RST_IMAGE_HEIGHT);
   logic        cfg_tile      = 1'b0;
   logic        cfg_center    = 1'b0;
   logic [15:0] image_mem [STORE_DEPTH];
   bit          loaded    [STORE_DEPTH];

   blit_result_type expected_blits[$];
   int              mismatch_count = 0;
   idle_mode_type   idle_mode = IDLE_NONE;
   int unsigned     SEND_IDLE_PCT [4] = '{0, 54, 0, 36};
   int unsigned     RECV_STALL_PCT[4] = '{0, 0, 54, 36};

   directed_row_type directed_rows [20] = '{
      '{OP_LOAD, 10'd0,    10'd0,    14'd0,     16'hF800, 1'b0, 1'b0, 32'd0,      16'h0000},
      '{OP_LOAD, 10'd0,    10'd0,    14'd16383, 16'h001F, 1'b0, 1'b0, 32'd0,      16'h0000},
      '{OP_LOAD, 10'd0,    10'd0,    14'd127,   16'h07E0, 1'b0, 1'b0, 32'd0,      16'h0000},
      '{OP_LOAD, 10'd0,    10'd0,    14'd16256, 16'hFFFF, 1'b0, 1'b0, 32'd0,      16'h0000},
      '{OP_LOAD, 10'd0,    10'd0,    14'd1,     16'hA5A5, 1'b0, 1'b0, 32'd0,      16'h0000},
      '{OP_LOAD, 10'd0,    10'd0,    14'd2,     16'h0000, 1'b0, 1'b0, 32'd0,      16'h0000},
      '{OP_MAP,  10'd0,    10'd0,    14'd0,     16'h0000, 1'b1, 1'b1, 32'd0,      16'h001F},
      '{OP_MAP,  10'd127,  10'd127,  14'd0,     16'h0000, 1'b1, 1'b1, 32'd81534,  16'hF800},
      '{OP_MAP,  10'd127,  10'd0,    14'd0,     16'h0000, 1'b1, 1'b1, 32'd254,    16'h07E0},
      '{OP_MAP,  10'd0,    10'd127,  14'd0,     16'h0000, 1'b1, 1'b1, 32'd81280,  16'hFFFF},
      '{OP_MAP,  10'd128,  10'd0,    14'd0,     16'h0000, 1'b1, 1'b0, 32'd256,    16'h0000},
      '{OP_MAP,  10'd0,    10'd128,  14'd0,     16'h0000, 1'b1, 1'b0, 32'd81920,  16'h0000},
      '{OP_MAP,  10'd319,  10'd239,  14'd0,     16'h0000, 1'b1, 1'b0, 32'd153598, 16'h0000},
      '{OP_MAP,  10'd320,  10'd0,    14'd0,     16'h0000, 1'b1, 1'b0, 32'd640,    16'h0000},
      '{OP_MAP,  10'd0,    10'd240,  14'd0,     16'h0000, 1'b1, 1'b0, 32'd153600, 16'h0000},
      '{OP_MAP,  10'd1023, 10'd1023, 14'h3FFF,  16'hFFFF, 1'b1, 1'b0, 32'd656766, 16'h0000},
      '{OP_MAP,  10'd1,    10'd0,    14'd0,     16'h0000, 1'b0, 1'b0, 32'd0,      16'h0000},
      '{OP_LOAD, 10'd0,    10'd0,    14'd1,     16'h5A5A, 1'b0, 1'b0, 32'd0,      16'h0000},
      '{OP_MAP,  10'd1,    10'd0,    14'd0,     16'h0000, 1'b0, 1'b0, 32'd0,      16'h0000},
      '{OP_MAP,  10'd2,    10'd0,    14'd0,     16'h0000, 1'b1, 1'b1, 32'd4,      16'h0000}
   };

   blit_setup_type blit_setups [8] = '{
      '{32'hFFFF_FFF0, 11'd1024, 11'd1024, 8'd128, 8'd128, 1'b1, 1'b0},
      '{32'h1000_0000, 11'd2047, 11'd2047, 8'd255, 8'd255, 1'b1, 1'b1},
      '{32'h0000_1234, 11'd64,   11'd48,   8'd16,  8'd8,   1'b1, 1'b1},
      '{32'hDEAD_BEEF, 11'd1,    11'd1,    8'd1,   8'd1,   1'b0, 1'b0},
      '{32'h8000_0000, 11'd0,    11'd600,  8'd128, 8'd0,   1'b1, 1'b1},
      '{32'h0000_00C8, 11'd200,  11'd150,  8'd0,   8'd5,   1'b1, 1'b1},
      '{32'h5555_5554, 11'd100,  11'd100,  8'd128, 8'd3,   1'b1, 1'b1},
      '{32'h0000_0000, 11'd40,   11'd200,  8'd7,   8'd127, 1'b0, 1'b1}
   };

   function automatic int clip(input int v, input int top);
      return (v > top) ? top : v;
   endfunction

   function automatic logic [15:0] red_blue_exchange(input logic [15:0] c);
      return {c[4:0], c[10:5], c[15:11]};
   endfunction

   function automatic bit axis_source(input int pos, input int scr, input int img,
                                      output int src);
      int off;
      int d;
      int r;
      off = 0;
      src = 0;
      if (img == 0)
         return 1'b0;
      if (cfg_center && img < scr)
         off = (scr - img) / 2;
      d = pos - off;
      if (cfg_tile) begin
         r = d % img;
         if (r < 0)
            r += img;
         src = r;
         return 1'b1;
      end
      if (d < 0 || d >= img)
         return 1'b0;
      src = d;
      return 1'b1;
   endfunction

   // store index a map of (x,y) reads, if the pixel is covered
   function automatic bit locate_source(input int x, input int y, output int idx);
      int sw;
      int sh;
      int iw;
      int ih;
      int sx;
      int sy;
      bit hit;
      sw  = clip(int'(cfg_screen_w), DEF_MAX_SCREEN_SIDE);
      sh  = clip(int'(cfg_screen_h), DEF_MAX_SCREEN_SIDE);
      iw  = clip(int'(cfg_image_w), DEF_MAX_IMAGE_SIDE);
      ih  = clip(int'(cfg_image_h), DEF_MAX_IMAGE_SIDE);
      idx = 0;
      hit = x < sw && y < sh;
      if (hit)
         hit = axis_source(x, sw, iw, sx);
      if (hit)
         hit = axis_source(y, sh, ih, sy);
      if (hit)
         idx = sy * iw + sx;
      return hit;
   endfunction

   function automatic blit_result_type predict_blit(input int x, input int y);
      blit_result_type res;
      int              idx;
      int              sw;
      sw            = clip(int'(cfg_screen_w), DEF_MAX_SCREEN_SIDE);
      res.valid_res = locate_source(x, y, idx);
      res.address   = cfg_fb_base + 32'(2 * (y * sw + x));
      res.pixel     = res.valid_res ? red_blue_exchange(image_mem[14'(idx)]) : 16'h0000;
      return res;
   endfunction

   task automatic csr_write(input logic [CSR_IW-1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         CSR_FB_BASE:       cfg_fb_base  = data;
         CSR_SCREEN_WIDTH:  cfg_screen_w = data[10:0];
         CSR_SCREEN_HEIGHT: cfg_screen_h = data[10:0];
         CSR_IMAGE_WIDTH:   cfg_image_w  = data[7:0];
         CSR_IMAGE_HEIGHT:  cfg_image_h  = data[7:0];
         CSR_TILE_MODE:     cfg_tile     = data[0];
         CSR_CENTER_MODE:   cfg_center   = data[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic push_request(input blit_req_type r, input bit typed,
                               input blit_result_type typed_res);
      while ($urandom_range(99) < SEND_IDLE_PCT[idle_mode]) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= r.op;
      req_bus.screen_x    <= r.x;
      req_bus.screen_y    <= r.y;
      req_bus.pixel_index <= r.index;
      req_bus.pixel_value <= r.value;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (r.op == OP_LOAD) begin
         image_mem[r.index] = r.value;
         loaded[r.index]    = 1'b1;
      end else begin
         expected_blits.push_back(typed ? typed_res : predict_blit(int'(r.x), int'(r.y)));
      end
      @(negedge clock);
   endtask

   task automatic random_item();
      blit_req_type r;
      blit_req_type fill;
      int           sw;
      int           sh;
      int           iw;
      int           ih;
      int           idx;
      sw      = clip(int'(cfg_screen_w), DEF_MAX_SCREEN_SIDE);
      sh      = clip(int'(cfg_screen_h), DEF_MAX_SCREEN_SIDE);
      iw      = clip(int'(cfg_image_w), DEF_MAX_IMAGE_SIDE);
      ih      = clip(int'(cfg_image_h), DEF_MAX_IMAGE_SIDE);
      r.x     = 10'($urandom_range(1023));
      r.y     = 10'($urandom_range(1023));
      r.index = 14'($urandom_range(16383));
      r.value = 16'($urandom_range(65535));
      if ($urandom_range(99) < 40) begin
         r.op = OP_LOAD;
         if (iw > 0 && ih > 0 && $urandom_range(3) != 0)
            r.index = 14'($urandom_range(ih - 1) * iw + $urandom_range(iw - 1));
      end else begin
         r.op = OP_MAP;
         if (sw > 0 && sh > 0 && $urandom_range(4) != 0) begin
            r.x = 10'($urandom_range(sw - 1));
            r.y = 10'($urandom_range(sh - 1));
         end
         // never read a store entry that has not been loaded
         if (locate_source(int'(r.x), int'(r.y), idx) && !loaded[14'(idx)]) begin
            fill       = r;
            fill.op    = OP_LOAD;
            fill.index = 14'(idx);
            fill.value = 16'($urandom_range(65535));
            push_request(fill, 1'b0, '0);
         end
      end
      push_request(r, 1'b0, '0);
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (expected_blits.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= RECV_STALL_PCT[idle_mode]);
      end
   end

   always @(posedge clock) begin
      blit_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_blits.size() == 0) begin
            mismatch_count++;
            $display("%0t: result expected none, got valid_res %0b address %h pixel %h",
                     $time, rsp_bus.valid_res, rsp_bus.address, rsp_bus.pixel);
         end else begin
            want = expected_blits.pop_front();
            if (rsp_bus.valid_res !== want.valid_res) begin
               mismatch_count++;
               $display("%0t: valid_res expected %0b got %0b", $time, want.valid_res,
                        rsp_bus.valid_res);
            end
            if (rsp_bus.address !== want.address) begin
               mismatch_count++;
               $display("%0t: address expected %h got %h", $time, want.address,
                        rsp_bus.address);
            end
            if (rsp_bus.pixel !== want.pixel) begin
               mismatch_count++;
               $display("%0t: pixel expected %h got %h", $time, want.pixel, rsp_bus.pixel);
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      blit_req_type    r;
      blit_result_type res;
      blit_setup_type  s;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = OP_LOAD;
      req_bus.screen_x    = '0;
      req_bus.screen_y    = '0;
      req_bus.pixel_index = '0;
      req_bus.pixel_value = '0;
      csr_we              = 1'b0;
      csr_index           = CSR_FB_BASE;
      csr_data            = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, reset configuration
      foreach (directed_rows[i]) begin
         r             = '{directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                           directed_rows[i].index, directed_rows[i].value};
         res           = '{directed_rows[i].exp_valid, directed_rows[i].exp_address,
                           directed_rows[i].exp_pixel};
         push_request(r, directed_rows[i].typed, res);
      end

      foreach (blit_setups[p]) begin
         s = blit_setups[p];
         idle_mode = IDLE_NONE;
         wait_drain();
         csr_write(CSR_FB_BASE, s.base);
         csr_write(CSR_SCREEN_WIDTH, 32'(s.sw));
         csr_write(CSR_SCREEN_HEIGHT, 32'(s.sh));
         csr_write(CSR_IMAGE_WIDTH, 32'(s.iw));
         csr_write(CSR_IMAGE_HEIGHT, 32'(s.ih));
         csr_write(CSR_TILE_MODE, 32'(s.tile));
         csr_write(CSR_CENTER_MODE, 32'(s.center));
         if (p == 2)
            csr_write(CSR_SPARE, 32'hFFFF_FFFF);
         csr_we <= 1'b0;
         for (int c = 0; c < 4; c++) begin
            idle_mode = idle_mode_type'(c);
            repeat (CHUNK_ITEMS) random_item();
         end
      end

      wait_drain();
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
